// ===== hw/rtl/mdj_pkg.sv =====
// Shared types, widths and helpers for the mask overlap Dice/Jaccard block.
package mdj_pkg;

  localparam int VAL_W     = 16;
  localparam int CNT_W     = 25;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int DEN_W     = CNT_W + 2;
  localparam int STEP_W    = 5;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_FILL_W  = 2;

  localparam logic [CNT_W-1:0]    MAX_VOXELS = CNT_W'(16777216);
  localparam logic [STEP_W-1:0]   STEP_INIT  = STEP_W'(FRAC_W);
  localparam logic [Q_FILL_W-1:0] Q_FULL_AT  = Q_FILL_W'(Q_DEPTH);

  typedef struct packed {
    logic [VAL_W-1:0] truth_value;
    logic [VAL_W-1:0] segment_value;
    logic             last_voxel;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  true_pos;
    logic [CNT_W-1:0]  false_pos;
    logic [CNT_W-1:0]  false_neg;
    logic [CNT_W-1:0]  true_neg;
    logic [FRAC_W-1:0] dice_frac;
    logic [FRAC_W-1:0] jaccard_frac;
    logic              empty_union;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] fp;
    logic [CNT_W-1:0] fn;
    logic [CNT_W-1:0] tn;
  } cnt_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c < MAX_VOXELS) ? c + CNT_W'(1) : c;
  endfunction

endpackage

// ===== hw/rtl/mdj_front.sv =====
// Front end: classifies voxel pairs and keeps the saturating confusion counts.
module mdj_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdj_pkg::in_word_t   in_word,
  input  mdj_pkg::q_stat_t    q_stat,
  output logic                q_push,
  output mdj_pkg::cnt_set_t   q_data
);

  mdj_pkg::cnt_set_t cnt_r;
  mdj_pkg::cnt_set_t cnt_nxt;
  logic              gt;
  logic              sg;
  logic              accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign gt       = |in_word.truth_value;
  assign sg       = |in_word.segment_value;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({gt, sg})
      2'b11: cnt_nxt.tp = mdj_pkg::sat_inc(cnt_r.tp);
      2'b01: cnt_nxt.fp = mdj_pkg::sat_inc(cnt_r.fp);
      2'b10: cnt_nxt.fn = mdj_pkg::sat_inc(cnt_r.fn);
      default: cnt_nxt.tn = mdj_pkg::sat_inc(cnt_r.tn);
    endcase
  end

  assign q_push = accept && in_word.last_voxel;
  assign q_data = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      if (in_word.last_voxel) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/mdj_queue.sv =====
// Two-entry queue of finished count sets between front and back.
module mdj_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mdj_pkg::cnt_set_t  push_data,
  input  logic               pop,
  output mdj_pkg::cnt_set_t  pop_data,
  output mdj_pkg::q_stat_t   q_stat
);

  mdj_pkg::cnt_set_t                   entry_r [mdj_pkg::Q_DEPTH];
  logic [mdj_pkg::Q_PTR_W-1:0]         wr_ptr_r;
  logic [mdj_pkg::Q_PTR_W-1:0]         rd_ptr_r;
  logic [mdj_pkg::Q_FILL_W-1:0]        fill_r;
  logic [mdj_pkg::Q_FILL_W-1:0]        fill_nxt;

  assign q_stat.full  = (fill_r == mdj_pkg::Q_FULL_AT);
  assign q_stat.empty = (fill_r == '0);
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + mdj_pkg::Q_FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - mdj_pkg::Q_FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + mdj_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + mdj_pkg::Q_PTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/mdj_div.sv =====
// Restoring fraction divider: one quotient bit per cycle, numerator at most divisor.
module mdj_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mdj_pkg::DEN_W-1:0]    num,
  input  logic [mdj_pkg::DEN_W-1:0]    den,
  output logic                         done,
  output logic [mdj_pkg::FRAC_W-1:0]   quo
);

  logic [mdj_pkg::DEN_W-1:0]  rem_r;
  logic [mdj_pkg::DEN_W-1:0]  den_r;
  logic [mdj_pkg::FRAC_W-1:0] quo_r;
  logic [mdj_pkg::STEP_W-1:0] step_r;
  logic                       done_r;
  logic [mdj_pkg::DEN_W:0]    trial;
  logic [mdj_pkg::DEN_W:0]    diff;
  logic                       ge;
  logic                       active;

  assign active = (step_r != '0);
  assign trial  = (step_r == mdj_pkg::STEP_INIT) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign diff   = trial - {1'b0, den_r};
  assign ge     = (trial >= {1'b0, den_r});
  assign done   = done_r;
  assign quo    = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (active) begin
      rem_r <= ge ? diff[mdj_pkg::DEN_W-1:0] : trial[mdj_pkg::DEN_W-1:0];
      quo_r <= {quo_r[mdj_pkg::FRAC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= active && (step_r == mdj_pkg::STEP_W'(1));
      if (start) begin
        step_r <= mdj_pkg::STEP_INIT;
      end else if (active) begin
        step_r <= step_r - mdj_pkg::STEP_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !active) else $error("divider restarted while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (active && !start && (den_r != '0) && (rem_r <= den_r)) |=> (rem_r < den_r))
    else $error("remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done longer than one cycle");
`endif

endmodule

// ===== hw/rtl/mdj_back.sv =====
// Back end: takes a count set, runs both ratio divisions and holds the result word.
module mdj_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdj_pkg::q_stat_t     q_stat,
  input  mdj_pkg::cnt_set_t    q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mdj_pkg::out_word_t   out_word
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  mdj_pkg::cnt_set_t            cnt_r;
  logic                         empty_r;
  mdj_pkg::out_word_t           out_r;
  logic                         out_valid_r;
  logic                         start;
  logic                         load_out;
  logic                         slot_free;
  logic [mdj_pkg::DEN_W-1:0]    tp_x;
  logic [mdj_pkg::DEN_W-1:0]    uni;
  logic [mdj_pkg::DEN_W-1:0]    dice_num;
  logic [mdj_pkg::DEN_W-1:0]    dice_den;
  logic                         dice_done;
  logic                         jac_done;
  logic [mdj_pkg::FRAC_W-1:0]   dice_quo;
  logic [mdj_pkg::FRAC_W-1:0]   jac_quo;

  assign tp_x     = {2'b00, q_data.tp};
  assign uni      = tp_x + {2'b00, q_data.fp} + {2'b00, q_data.fn};
  assign dice_num = {1'b0, q_data.tp, 1'b0};
  assign dice_den = uni + tp_x;

  assign slot_free = !out_valid_r || !out_stall;
  assign start     = (state_r == ST_IDLE) && !q_stat.empty;
  assign q_pop     = start;
  assign load_out  = (state_r == ST_WAIT) && slot_free;

  mdj_div u_dice (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (dice_num),
    .den   (dice_den),
    .done  (dice_done),
    .quo   (dice_quo)
  );

  mdj_div u_jac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (tp_x),
    .den   (uni),
    .done  (jac_done),
    .quo   (jac_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (dice_done) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r   <= q_data;
      empty_r <= (uni == '0);
    end
    if (load_out) begin
      out_r.true_pos     <= cnt_r.tp;
      out_r.false_pos    <= cnt_r.fp;
      out_r.false_neg    <= cnt_r.fn;
      out_r.true_neg     <= cnt_r.tn;
      out_r.dice_frac    <= empty_r ? '0 : dice_quo;
      out_r.jaccard_frac <= empty_r ? '0 : jac_quo;
      out_r.empty_union  <= empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  a_done_pair: assert property (@(posedge clk) disable iff (!rst_n)
    dice_done == jac_done) else $error("dividers out of step");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.empty_union) |-> ((out_r.dice_frac == '0) && (out_r.jaccard_frac == '0)))
    else $error("empty union with nonzero ratio");
`endif

endmodule

// ===== hw/rtl/mask_overlap_dice_jaccard.sv =====
// Top level of the mask overlap Dice/Jaccard block.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  mdj_pkg::in_word_t (voxel pair, last flag)
//   out_     output     out_valid/out_stall  mdj_pkg::out_word_t (counts, ratios, empty)
//
// One voxel pair per cycle unless in_stall is high; in_stall rises only while two finished volumes wait.
// Each result is set by 17 divider iterations.
// The back end handles one volume at a time; the queue holds up to two more.
// Reset clears the counters, queue and out_valid; out_word holds while out_valid and out_stall are high.
module mask_overlap_dice_jaccard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdj_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mdj_pkg::out_word_t  out_word
);

  mdj_pkg::q_stat_t  q_stat;
  mdj_pkg::cnt_set_t push_data;
  mdj_pkg::cnt_set_t pop_data;
  logic              push;
  logic              pop;

  mdj_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_stat   (q_stat),
    .q_push   (push),
    .q_data   (push_data)
  );

  mdj_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  mdj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== test/mdj_overlap_checker.sv =====
`timescale 1ns / 1ps
// Checker for mask_overlap_dice_jaccard: predicts counts and ratios, compares result words.
module mdj_overlap_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mdj_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mdj_pkg::out_word_t out_word,
  output int                 errors,
  output int                 pending
);

  localparam int PRINT_CAP = 200;

  logic [mdj_pkg::CNT_W-1:0] tp_acc;
  logic [mdj_pkg::CNT_W-1:0] fp_acc;
  logic [mdj_pkg::CNT_W-1:0] fn_acc;
  logic [mdj_pkg::CNT_W-1:0] tn_acc;
  mdj_pkg::out_word_t        score_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [mdj_pkg::CNT_W-1:0] count_up(
    input logic [mdj_pkg::CNT_W-1:0] c);
    if (c >= mdj_pkg::MAX_VOXELS) return c;
    return c + mdj_pkg::CNT_W'(1);
  endfunction

  function automatic logic [mdj_pkg::FRAC_W-1:0] frac_of(input longint unsigned num,
                                                         input longint unsigned den);
    if (den == 0) return '0;
    return mdj_pkg::FRAC_W'((num << mdj_pkg::FRAC_BITS) / den);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < PRINT_CAP)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic take_pair(input mdj_pkg::in_word_t w);
    logic               gt;
    logic               sg;
    longint unsigned    tp;
    longint unsigned    uni;
    mdj_pkg::out_word_t r;
    gt = |w.truth_value;
    sg = |w.segment_value;
    if (gt && sg) tp_acc = count_up(tp_acc);
    else if (sg) fp_acc = count_up(fp_acc);
    else if (gt) fn_acc = count_up(fn_acc);
    else tn_acc = count_up(tn_acc);
    if (w.last_voxel) begin
      tp  = tp_acc;
      uni = tp + fp_acc + fn_acc;
      r.true_pos     = tp_acc;
      r.false_pos    = fp_acc;
      r.false_neg    = fn_acc;
      r.true_neg     = tn_acc;
      r.dice_frac    = frac_of(2 * tp, uni + tp);
      r.jaccard_frac = frac_of(tp, uni);
      r.empty_union  = (uni == 0);
      score_q.push_back(r);
      tp_acc = '0;
      fp_acc = '0;
      fn_acc = '0;
      tn_acc = '0;
    end
  endtask

  task automatic check_score(input mdj_pkg::out_word_t got);
    mdj_pkg::out_word_t want;
    if (score_q.size() == 0) begin
      report_mismatch("unexpected result word", 1, 0);
      return;
    end
    want = score_q.pop_front();
    if (got.true_pos != want.true_pos)
      report_mismatch("true_pos", got.true_pos, want.true_pos);
    if (got.false_pos != want.false_pos)
      report_mismatch("false_pos", got.false_pos, want.false_pos);
    if (got.false_neg != want.false_neg)
      report_mismatch("false_neg", got.false_neg, want.false_neg);
    if (got.true_neg != want.true_neg)
      report_mismatch("true_neg", got.true_neg, want.true_neg);
    if (got.dice_frac != want.dice_frac)
      report_mismatch("dice_frac", got.dice_frac, want.dice_frac);
    if (got.jaccard_frac != want.jaccard_frac)
      report_mismatch("jaccard_frac", got.jaccard_frac, want.jaccard_frac);
    if (got.empty_union != want.empty_union)
      report_mismatch("empty_union", got.empty_union, want.empty_union);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tp_acc = '0;
      fp_acc = '0;
      fn_acc = '0;
      tn_acc = '0;
      score_q.delete();
    end else begin
      if (in_valid && !in_stall) take_pair(in_word);
      if (out_valid && !out_stall) check_score(out_word);
    end
    pending = score_q.size();
  end

endmodule

// ===== test/mask_overlap_dice_jaccard_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for mask_overlap_dice_jaccard: clock, reset, stimulus, stalls and verdict.
module mask_overlap_dice_jaccard_tb;

  localparam int VOXEL_TARGET = 1000;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 700;
  localparam int IDLE_PCT     = 21;
  localparam int DRAIN_CYCLES = 40;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  mdj_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mdj_pkg::out_word_t out_word;
  int                 errors;
  int                 pending;
  int                 words_sent = 0;
  int                 quiet      = 0;
  bit                 held       = 1'b0;

  always #5 clk = ~clk;

  mask_overlap_dice_jaccard DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  mdj_overlap_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic mdj_pkg::in_word_t vox(input logic [mdj_pkg::VAL_W-1:0] t,
                                            input logic [mdj_pkg::VAL_W-1:0] s,
                                            input logic last);
    mdj_pkg::in_word_t w;
    w.truth_value   = t;
    w.segment_value = s;
    w.last_voxel    = last;
    return w;
  endfunction

  function automatic logic [mdj_pkg::VAL_W-1:0] fg_value();
    if ($urandom_range(0, 3) == 0)
      return mdj_pkg::VAL_W'(1) << $urandom_range(0, mdj_pkg::VAL_W - 1);
    return mdj_pkg::VAL_W'($urandom_range(1, 65535));
  endfunction

  function automatic int fg_pct();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 100;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  function automatic bit in_calm();
    return words_sent >= CALM_FROM && words_sent < CALM_TO;
  endfunction

  task automatic send_pair(input mdj_pkg::in_word_t w);
    int idle_pct;
    idle_pct = in_calm() ? 0 : IDLE_PCT;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_volume(input int len, input int t_pct, input int s_pct);
    logic [mdj_pkg::VAL_W-1:0] t;
    logic [mdj_pkg::VAL_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      t = ($urandom_range(0, 99) < t_pct) ? fg_value() : '0;
      s = ($urandom_range(0, 99) < s_pct) ? fg_value() : '0;
      send_pair(vox(t, s, i == len - 1));
    end
  endtask

  // receiver: random stalls, one long hold, one calm stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (in_calm()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty union, then perfect overlap on one voxel
    send_pair(vox(16'h0000, 16'h0000, 1'b1));
    send_pair(vox(16'hFFFF, 16'hFFFF, 1'b1));
    // one of each class
    send_pair(vox(16'h0001, 16'h0000, 1'b0));
    send_pair(vox(16'h0000, 16'h0001, 1'b0));
    send_pair(vox(16'h8000, 16'h8000, 1'b0));
    send_pair(vox(16'h0000, 16'h0000, 1'b1));
    // disjoint masks: zero ratios without empty union
    send_pair(vox(16'hFFFF, 16'h0000, 1'b0));
    send_pair(vox(16'h0000, 16'hFFFF, 1'b1));
    // fractional ratios
    send_pair(vox(16'h5555, 16'hAAAA, 1'b0));
    send_pair(vox(16'h0000, 16'h7FFF, 1'b0));
    send_pair(vox(16'hAAAA, 16'h5555, 1'b1));
    // background only
    for (int i = 0; i < 4; i++) send_pair(vox(16'h0000, 16'h0000, i == 3));
    // last flag on a foreground-only-in-truth voxel
    send_pair(vox(16'h00FF, 16'hFF00, 1'b0));
    send_pair(vox(16'hFF00, 16'h0000, 1'b1));
    while (words_sent < VOXEL_TARGET) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 16);
      send_volume(len, fg_pct(), fg_pct());
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mdj_pkg.sv
hw/rtl/mdj_front.sv
hw/rtl/mdj_queue.sv
hw/rtl/mdj_div.sv
hw/rtl/mdj_back.sv
hw/rtl/mask_overlap_dice_jaccard.sv
test/mdj_overlap_checker.sv
test/mask_overlap_dice_jaccard_tb.sv
